### rtl/core/sha256_pkg.sv
package sha256_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds = 64;
  localparam int unsigned HashWords = 8;
  localparam int unsigned MsgBytesW = 61;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] idx);
    word_t h;
    unique case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  localparam logic [7:0] PadByte = 8'h80;

endpackage

### rtl/core/sha256_message_hasher_unit.sv
// A word that does not fill a block is stored and the unit stays idle; a word that fills
// one starts 64 rounds and then a fold into the hash. A last word adds one or two padded
// blocks, each with its rounds and fold, and then the 8 digest words, one digest word per cycle.
// Throughput: one SHA-256 round per cycle in a single shared round unit, 64 per block.
// Reset (synchronous, rst_n low) restores the initial hash and clears counts and state.
// Digest words appear for one cycle each under out_valid; the receiver cannot stall.
module sha256_message_hasher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  output logic        out_valid,
  output logic [31:0] out_digest_word,
  output logic        out_digest_last
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_FOLD  = 5'b00100,
    ST_PAD2  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  sha256_pkg::word_t hash_r [8];
  sha256_pkg::word_t w_r [16];   // message schedule window, also the block buffer
  sha256_pkg::word_t a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [60:0] msg_bytes_r;
  logic [3:0]  slot_r;
  logic [5:0]  round_r;
  logic [2:0]  out_idx_r;
  logic        final_r;     // current compression is the length block
  logic        need_pad2_r; // after this block, a length-only block follows
  logic        pad_lead_r;  // the length-only block also starts with the 0x80 byte

  function automatic sha256_pkg::word_t rotr(input sha256_pkg::word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Round unit.
  sha256_pkg::word_t s0, s1, t1, t2, sg0, sg1, w_new;
  always_comb begin
    s1 = rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25);
    s0 = rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22);
    t1 = h_r + s1 + ((e_r & f_r) ^ (~e_r & g_r)) + sha256_pkg::round_k(round_r) + w_r[0];
    t2 = s0 + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
    sg0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    sg1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = sg1 + w_r[9] + sg0 + w_r[0];
  end

  // Padding of the last word.
  logic [2:0]  cnt;
  logic [60:0] bytes_sum;
  logic [63:0] bit_len;
  logic [3:0]  pad_slot;
  sha256_pkg::word_t keep, mark, pad_word;
  always_comb begin
    cnt = (in_valid_bytes > 3'd4 || !in_last_word) ? 3'd4 : in_valid_bytes;
    bytes_sum = msg_bytes_r + 61'(cnt);
    bit_len = {bytes_sum, 3'b000};
    pad_slot = (cnt == 3'd4) ? slot_r + 4'd1 : slot_r;
    unique case (cnt[1:0])
      2'd0: begin keep = 32'h0; mark = {sha256_pkg::PadByte, 24'h0}; end
      2'd1: begin keep = 32'hff000000; mark = {8'h0, sha256_pkg::PadByte, 16'h0}; end
      2'd2: begin keep = 32'hffff0000; mark = {16'h0, sha256_pkg::PadByte, 8'h0}; end
      default: begin keep = 32'hffffff00; mark = {24'h0, sha256_pkg::PadByte}; end
    endcase
    pad_word = (in_data_word & keep) | mark;
  end

  logic [63:0] len_r;
  logic        accept;
  assign accept = start && (state_r == ST_IDLE);
  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  state_nxt = state_r;
      ST_ROUND: if (round_r == 6'd63) state_nxt = ST_FOLD;
      ST_FOLD:  state_nxt = need_pad2_r ? ST_PAD2 : (final_r ? ST_OUT : ST_IDLE);
      ST_PAD2:  state_nxt = ST_ROUND;
      ST_OUT:   if (out_idx_r == 3'd7) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    if (accept) begin
      if (in_last_word || slot_r == 4'd15) state_nxt = ST_ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      msg_bytes_r <= '0;
      slot_r <= '0;
      round_r <= '0;
      out_idx_r <= '0;
      final_r <= 1'b0;
      need_pad2_r <= 1'b0;
      pad_lead_r <= 1'b0;
      for (int i = 0; i < 8; i++) hash_r[i] <= sha256_pkg::init_h(3'(i));
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: if (accept) begin
          msg_bytes_r <= bytes_sum;
          len_r <= bit_len;
          round_r <= '0;
          {a_r, b_r, c_r, d_r} <= {hash_r[0], hash_r[1], hash_r[2], hash_r[3]};
          {e_r, f_r, g_r, h_r} <= {hash_r[4], hash_r[5], hash_r[6], hash_r[7]};
          if (!in_last_word) begin
            w_r[slot_r] <= in_data_word;
            slot_r <= slot_r + 4'd1;
            final_r <= 1'b0;
            need_pad2_r <= 1'b0;
            pad_lead_r <= 1'b0;
          end else if (cnt == 3'd4 && slot_r == 4'd15) begin
            // Word fills the block; padding goes to a fresh block.
            w_r[15] <= in_data_word;
            final_r <= 1'b0;
            need_pad2_r <= 1'b1;
            pad_lead_r <= 1'b1;
            slot_r <= 4'd0;
          end else begin
            if (cnt == 3'd4) w_r[slot_r] <= in_data_word;
            for (int i = 0; i < 16; i++) begin
              if (4'(i) == pad_slot) begin
                w_r[i] <= (cnt == 3'd4) ? {sha256_pkg::PadByte, 24'h0} : pad_word;
              end else if (4'(i) > pad_slot) begin
                if (pad_slot < 4'd14 && i == 14) w_r[i] <= bit_len[63:32];
                else if (pad_slot < 4'd14 && i == 15) w_r[i] <= bit_len[31:0];
                else w_r[i] <= '0;
              end
            end
            if (pad_slot < 4'd14) begin
              final_r <= 1'b1;
              need_pad2_r <= 1'b0;
            end else begin
              final_r <= 1'b0;
              need_pad2_r <= 1'b1;
            end
            pad_lead_r <= 1'b0;
            slot_r <= 4'd0;
          end
        end
        ST_ROUND: begin
          h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
          d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= w_new;
          round_r <= round_r + 6'd1;
        end
        ST_FOLD: begin
          hash_r[0] <= hash_r[0] + a_r; hash_r[1] <= hash_r[1] + b_r;
          hash_r[2] <= hash_r[2] + c_r; hash_r[3] <= hash_r[3] + d_r;
          hash_r[4] <= hash_r[4] + e_r; hash_r[5] <= hash_r[5] + f_r;
          hash_r[6] <= hash_r[6] + g_r; hash_r[7] <= hash_r[7] + h_r;
          out_idx_r <= '0;
        end
        ST_PAD2: begin
          w_r[0] <= pad_lead_r ? {sha256_pkg::PadByte, 24'h0} : '0;
          for (int i = 1; i < 14; i++) w_r[i] <= '0;
          w_r[14] <= len_r[63:32];
          w_r[15] <= len_r[31:0];
          {a_r, b_r, c_r, d_r} <= {hash_r[0], hash_r[1], hash_r[2], hash_r[3]};
          {e_r, f_r, g_r, h_r} <= {hash_r[4], hash_r[5], hash_r[6], hash_r[7]};
          round_r <= '0;
          final_r <= 1'b1;
          need_pad2_r <= 1'b0;
          pad_lead_r <= 1'b0;
        end
        ST_OUT: begin
          out_idx_r <= out_idx_r + 3'd1;
          if (out_idx_r == 3'd7) begin
            for (int i = 0; i < 8; i++) hash_r[i] <= sha256_pkg::init_h(3'(i));
            msg_bytes_r <= '0;
            final_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = (state_r == ST_OUT);
  assign out_digest_word = hash_r[out_idx_r];
  assign out_digest_last = out_valid && (out_idx_r == 3'd7);

endmodule

### rtl/core/sha256_checker.sv
module sha256_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_digest_last
);

  a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_digest_last |-> out_valid) else $error("digest_last without valid");

  a_busy_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("output while idle");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_digest_last |=> !out_valid) else $error("output after last digest word");

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("output right after reset");

endmodule

bind sha256_message_hasher_unit sha256_checker u_sha256_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_valid(out_valid), .out_digest_last(out_digest_last)
);

### test/sha256_message_hasher_unit_tb.sv
`timescale 1ns / 1ps

module sha256_message_hasher_unit_tb;

  localparam int unsigned LimitCycles = 400000;

  typedef struct {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } msg_word_t;

  typedef struct {
    logic [31:0] digest_word;
    logic        digest_last;
  } digest_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_data_word;
  logic [2:0]  in_valid_bytes;
  logic        in_last_word;
  logic        out_valid;
  logic [31:0] out_digest_word;
  logic        out_digest_last;

  sha256_message_hasher_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data_word(in_data_word), .in_valid_bytes(in_valid_bytes),
    .in_last_word(in_last_word), .out_valid(out_valid),
    .out_digest_word(out_digest_word), .out_digest_last(out_digest_last)
  );

  // Predictor state.
  sha256_pkg::word_t chain[8];
  sha256_pkg::word_t blk[16];
  logic [60:0] byte_count;
  logic [3:0]  slot;

  msg_word_t pending_words[$];
  digest_t   expected_digests[$];
  int unsigned sender_idle_pct;
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned digests_seen;
  int unsigned messages_sent;
  int unsigned cycles;
  logic        busy_prev;   // busy as seen by the rising edge that judges the offer

  localparam sha256_pkg::word_t IvTab[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam sha256_pkg::word_t KTab[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic sha256_pkg::word_t rotr(sha256_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_into_chain();
    sha256_pkg::word_t w[64];
    sha256_pkg::word_t v[8];
    sha256_pkg::word_t t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++)
      w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic reset_hasher();
    for (int i = 0; i < 8; i++) chain[i] = IvTab[i];
    byte_count = '0;
    slot = '0;
  endtask

  task automatic store_word(sha256_pkg::word_t wd);
    blk[slot] = wd;
    slot = slot + 4'd1;
    if (slot == 4'd0) compress_into_chain();
  endtask

  task automatic hash_word(msg_word_t it);
    int unsigned       n;
    sha256_pkg::word_t wd;
    sha256_pkg::word_t keep;
    logic [63:0]       bit_len;
    digest_t           d;
    n = it.valid_bytes;
    wd = it.data_word;
    if (n > 4 || !it.last_word) n = 4;
    byte_count = byte_count + 61'(n);
    if (!it.last_word) begin
      store_word(wd);
      return;
    end
    if (n == 4) begin
      store_word(wd);
      n = 0;
      wd = '0;
    end
    keep = (n == 0) ? 32'h0 : ~(32'hffffffff >> (8 * n));
    blk[slot] = (wd & keep) | (32'h80000000 >> (8 * n));
    if (slot >= 4'd14) begin
      for (int i = slot + 1; i < 16; i++) blk[i] = '0;
      compress_into_chain();
      for (int i = 0; i < 14; i++) blk[i] = '0;
    end else begin
      for (int i = slot + 1; i < 14; i++) blk[i] = '0;
    end
    bit_len = {byte_count, 3'b000};
    blk[14] = bit_len[63:32];
    blk[15] = bit_len[31:0];
    compress_into_chain();
    for (int i = 0; i < 8; i++) begin
      d.digest_word = chain[i];
      d.digest_last = (i == 7);
      expected_digests.push_back(d);
    end
    reset_hasher();
  endtask

  task automatic queue_word(logic [31:0] dw, logic [2:0] vb, logic lw);
    msg_word_t it;
    it.data_word = dw;
    it.valid_bytes = vb;
    it.last_word = lw;
    pending_words.push_back(it);
  endtask

  // A message of len full words, then a last word carrying tail_bytes bytes.
  task automatic queue_message(int len, logic [2:0] tail_bytes);
    for (int i = 0; i < len; i++) begin
      // Noise in valid_bytes of non-last words must be ignored.
      queue_word($urandom, ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd4, 1'b0);
    end
    queue_word($urandom, tail_bytes, 1'b1);
  endtask

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Driver: updates at the falling edge. busy only changes at rising edges, so the
  // value kept from the previous falling edge is what judged the offered transaction.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy_prev) begin
      // Hold the offered word until it is taken.
    end else begin
      if (start) begin
        void'(pending_words.pop_front());
        words_sent++;
      end
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        hash_word(pending_words[0]);
        if (pending_words[0].last_word) messages_sent++;
        start <= 1'b1;
        in_data_word <= pending_words[0].data_word;
        in_valid_bytes <= pending_words[0].valid_bytes;
        in_last_word <= pending_words[0].last_word;
      end else begin
        start <= 1'b0;
        in_data_word <= $urandom;
        in_valid_bytes <= 3'($urandom);
        in_last_word <= 1'($urandom);
      end
    end
    busy_prev = busy;
  end

  // Monitor and checker.
  always @(posedge clk) begin
    digest_t exp_d;
    if (rst_n) begin
      cycles++;
      if (out_valid) begin
        digests_seen++;
        if (expected_digests.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected digest word %h last %b", out_digest_word, out_digest_last);
        end else begin
          exp_d = expected_digests.pop_front();
          if (exp_d.digest_word !== out_digest_word || exp_d.digest_last !== out_digest_last)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("digest mismatch: expected %h/%b, got %h/%b", exp_d.digest_word,
                       exp_d.digest_last, out_digest_word, out_digest_last);
          end
        end
      end
      if (cycles > LimitCycles) begin
        $display("timeout after %0d cycles", cycles);
        $display("sha256_message_hasher_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic queue_random_traffic(int n_words);
    int target;
    target = pending_words.size() + n_words;
    while (pending_words.size() < target) begin
      // Mostly short messages, now and then a long one.
      if ($urandom_range(0, 9) == 0) queue_message($urandom_range(14, 40), 3'($urandom));
      else queue_message($urandom_range(0, 17), 3'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || start) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    busy_prev = 1'b0;
    in_data_word = '0;
    in_valid_bytes = '0;
    in_last_word = 1'b0;
    sender_idle_pct = 9;
    mismatches = 0;
    words_sent = 0;
    digests_seen = 0;
    messages_sent = 0;
    cycles = 0;
    reset_hasher();
    // Directed: "abc", empty message, extreme words, length-field boundaries.
    queue_word(32'h61626300, 3'd3, 1'b1);
    queue_word(32'hffffffff, 3'd0, 1'b1);
    queue_word(32'hffffffff, 3'd4, 1'b1);
    queue_word(32'h00000000, 3'd7, 1'b1);
    queue_word(32'h12345678, 3'd1, 1'b1);
    queue_word(32'hffffffff, 3'd2, 1'b0);
    queue_word(32'hffffffff, 3'd5, 1'b1);
    queue_message(13, 3'd4);  // pad mark lands in word 14
    queue_message(14, 3'd3);  // pad mark in word 14 after a partial word
    queue_message(15, 3'd0);  // empty last word at slot 15
    queue_message(15, 3'd4);  // block fills exactly, length in a fresh block
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    queue_random_traffic(60);
    wait_drained();
    sender_idle_pct = 70;
    queue_random_traffic(60);
    wait_drained();
    sender_idle_pct = 0;
    queue_random_traffic(60);
    wait_drained();
    while (expected_digests.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d words in %0d messages sent, %0d digest words checked",
             words_sent, messages_sent, digests_seen);
    if (mismatches == 0 && expected_digests.size() == 0) begin
      $display("sha256_message_hasher_unit regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("sha256_message_hasher_unit regression: fail");
    end
    $finish;
  end

endmodule
